// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the correlation engine.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define WPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/wpc_pkg.sv -----
// Package for the windowed correlation engine: word types, widths, codes and
// the command and status bundles between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wpc_pkg;

  // Fixed field widths.
  localparam int SAMPLE_BITS     = 16;
  localparam int STORE_DEPTH_DEF = 1024;
  localparam int IDX_W           = 10;
  localparam int LEN_W           = 11;
  localparam int VAL_W           = 48;
  localparam int STAT_W          = 2;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 16;
  localparam int MIN_PAIRS       = 5;

  // Accumulator widths for up to 2047 pairs of 16-bit samples.
  localparam int SUM_W = 27;
  localparam int SQ_W  = 41;
  localparam int XY_W  = 42;

  // Post-processing widths.
  localparam int SW     = 54;
  localparam int OPW    = 56;
  localparam int PW     = 112;
  localparam int DEN_W  = 104;
  localparam int DVD_W  = 168;
  localparam int QW     = 72;
  localparam int ROOT_W = 31;
  localparam int FRAC_R = 60;
  localparam int FRAC_C = 16;

  // Cycles the read pipeline needs to empty after the last read.
  localparam int DRAIN_CYC = 3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FEW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COV_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MISSING  = 1'b1;

  // Input word kinds.
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic                          kind;
    logic [IDX_W-1:0]              load_index;
    logic signed [SAMPLE_BITS-1:0] x_sample;
    logic signed [SAMPLE_BITS-1:0] y_sample;
    logic [IDX_W-1:0]              start_x;
    logic [IDX_W-1:0]              start_y;
    logic [LEN_W-1:0]              window_len;
  } in_word_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [STAT_W-1:0]       status;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_RANGE, S_READ, S_DRAIN, S_COUNT, S_MUL_GO, S_MUL_WAIT, S_VAR,
    S_DIV_GO, S_DIV_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_RESULT
  } ctrl_state_t;

  // Products formed by the shared multiplier, in sequence order.
  typedef enum logic [3:0] {
    MS_NSX2, MS_SXSX, MS_NSY2, MS_SYSY, MS_NSXY, MS_SXSY, MS_NN1, MS_MAG2, MS_VARP
  } mul_sel_t;

  typedef enum logic [1:0] {
    RES_OK, RES_FEW, RES_RANGE
  } res_kind_t;

  typedef struct packed {
    logic      in_take;
    logic      rd_en;
    logic      mul_start;
    mul_sel_t  mul_sel;
    logic      div_start;
    logic      sqrt_start;
    logic      res_load;
    res_kind_t res_kind;
  } dp_cmd_t;

  typedef struct packed {
    logic range_bad;
    logic len_zero;
    logic last_read;
    logic few_pairs;
    logic var_zero;
    logic cov_mode;
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic mul_busy;
    logic div_busy;
    logic sqrt_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/wpc_mul.sv -----
// Shift-and-add multiplier, one multiplier bit per cycle, stops early once the
// remaining multiplier bits are zero. Depends on wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_mul (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [wpc_pkg::OPW-1:0] a,
  input  logic [wpc_pkg::OPW-1:0] b,
  output logic                    busy,
  output logic                    done,
  output logic [wpc_pkg::PW-1:0]  prod
);
  import wpc_pkg::*;

  logic          busy_r;
  logic          done_r;
  logic [PW-1:0] a_r;
  logic [OPW-1:0] b_r;
  logic [PW-1:0] acc_r;

  // Control: run until the multiplier is used up.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (b_r == '0)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: add the shifted multiplicand for each set multiplier bit.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= PW'(a);
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r && (b_r != '0)) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= a_r << 1;
      b_r <= b_r >> 1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

`default_nettype wire

// ----- rtl/core/wpc_div.sv -----
// Restoring long divider, one quotient bit per cycle over the whole dividend.
// Keeps the low quotient bits only. Depends on wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [wpc_pkg::DVD_W-1:0] dividend,
  input  logic [wpc_pkg::DEN_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [wpc_pkg::QW-1:0]    quotient
);
  import wpc_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DEN_W-1:0] div_r;
  logic [DEN_W-1:0] rem_r;
  logic [QW-1:0]    q_r;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    ge    = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  // Control: count the dividend bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder stays below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      q_r   <= {q_r[QW-2:0], ge};
      dvd_r <= dvd_r << 1;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

// ----- rtl/core/wpc_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
// Gives the floor of the root of a 2*ROOT_W-bit radicand. Depends on wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_sqrt (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [2*wpc_pkg::ROOT_W-1:0] radicand,
  output logic                         busy,
  output logic                         done,
  output logic [wpc_pkg::ROOT_W-1:0]   root
);
  import wpc_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W+1:0]  cur;
  logic [REM_W+1:0]  trial;
  logic              ge;
  logic [REM_W+1:0]  diff;

  // Bring down two radicand bits and try a one in the next root position.
  always_comb begin
    cur   = {rem_r, rad_r[RAD_W-1 -: 2]};
    trial = (REM_W + 2)'({root_r, 2'b01});
    ge    = cur >= trial;
    diff  = cur - trial;
  end

  // Control: one pass per root bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: the remainder never exceeds twice the partial root.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
      rad_r  <= rad_r << 2;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ----- rtl/core/wpc_datapath.sv -----
// Datapath: sample stores, window accumulators, post-processing registers and
// the shared multiplier, divider and square-root units. Depends on wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_datapath #(
  parameter int STORE_DEPTH = wpc_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  wpc_pkg::in_word_t              in_data,
  input  logic                           cfg_we,
  input  logic [wpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wpc_pkg::dp_cmd_t               cmd,
  output wpc_pkg::dp_stat_t              st,
  output wpc_pkg::out_word_t             out_data
);
  import wpc_pkg::*;

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int RNG_W = ((AW > LEN_W) ? AW : LEN_W) + 1;
  localparam logic [SAMPLE_BITS-1:0] MISSING_RST = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // Configuration registers.
  logic                   cov_mode_r;
  logic [SAMPLE_BITS-1:0] missing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cov_mode_r <= 1'b0;
      missing_r  <= MISSING_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COV_MODE: cov_mode_r <= cfg_wdata[0];
        REG_MISSING:  missing_r  <= cfg_wdata[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Window fields of the word in progress.
  logic [IDX_W-1:0] sx_r;
  logic [IDX_W-1:0] sy_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] k_r;
  logic             take_load;
  logic             take_comp;
  logic             load_ok;

  assign take_load = cmd.in_take && (in_data.kind == KIND_LOAD);
  assign take_comp = cmd.in_take && (in_data.kind == KIND_COMPUTE);
  assign load_ok   = RNG_W'(in_data.load_index) < RNG_W'(STORE_DEPTH);

  always_ff @(posedge clk) begin
    if (take_comp) begin
      sx_r  <= in_data.start_x;
      sy_r  <= in_data.start_y;
      len_r <= in_data.window_len;
      k_r   <= '0;
    end else if (cmd.rd_en) begin
      k_r <= k_r + 1'b1;
    end
  end

  // Sample stores with registered read data.
  logic [SAMPLE_BITS-1:0] x_mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] y_mem [STORE_DEPTH];
  logic [AW-1:0]          waddr;
  logic [AW-1:0]          raddr_x;
  logic [AW-1:0]          raddr_y;
  logic [SAMPLE_BITS-1:0] rdx_r;
  logic [SAMPLE_BITS-1:0] rdy_r;

  assign waddr   = AW'(in_data.load_index);
  assign raddr_x = AW'(RNG_W'(sx_r) + RNG_W'(k_r));
  assign raddr_y = AW'(RNG_W'(sy_r) + RNG_W'(k_r));

  always_ff @(posedge clk) begin
    if (take_load && load_ok) begin
      x_mem[waddr] <= in_data.x_sample;
      y_mem[waddr] <= in_data.y_sample;
    end
    if (cmd.rd_en) begin
      rdx_r <= x_mem[raddr_x];
      rdy_r <= y_mem[raddr_y];
    end
  end

  // Product stage, with the missing-sample test.
  logic                          v1_r;
  logic                          v2_r;
  logic signed [SAMPLE_BITS-1:0] xs_r;
  logic signed [SAMPLE_BITS-1:0] ys_r;
  logic [2*SAMPLE_BITS-2:0]      px2_r;
  logic [2*SAMPLE_BITS-2:0]      py2_r;
  logic signed [2*SAMPLE_BITS-1:0] pxy_r;
  logic signed [2*SAMPLE_BITS-1:0] mxx;
  logic signed [2*SAMPLE_BITS-1:0] myy;
  logic signed [2*SAMPLE_BITS-1:0] mxy;

  always_comb begin
    mxx = $signed(rdx_r) * $signed(rdx_r);
    myy = $signed(rdy_r) * $signed(rdy_r);
    mxy = $signed(rdx_r) * $signed(rdy_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r && (rdx_r != missing_r) && (rdy_r != missing_r);
    end
  end

  always_ff @(posedge clk) begin
    xs_r  <= $signed(rdx_r);
    ys_r  <= $signed(rdy_r);
    px2_r <= mxx[2*SAMPLE_BITS-2:0];
    py2_r <= myy[2*SAMPLE_BITS-2:0];
    pxy_r <= mxy;
  end

  // Window sums.
  logic signed [SUM_W-1:0] sumx_r;
  logic signed [SUM_W-1:0] sumy_r;
  logic [SQ_W-1:0]         sumx2_r;
  logic [SQ_W-1:0]         sumy2_r;
  logic signed [XY_W-1:0]  sumxy_r;
  logic [LEN_W-1:0]        n_r;

  always_ff @(posedge clk) begin
    if (take_comp) begin
      sumx_r  <= '0;
      sumy_r  <= '0;
      sumx2_r <= '0;
      sumy2_r <= '0;
      sumxy_r <= '0;
      n_r     <= '0;
    end else if (v2_r) begin
      sumx_r  <= sumx_r + SUM_W'(xs_r);
      sumy_r  <= sumy_r + SUM_W'(ys_r);
      sumx2_r <= sumx2_r + SQ_W'(px2_r);
      sumy2_r <= sumy2_r + SQ_W'(py2_r);
      sumxy_r <= sumxy_r + XY_W'(pxy_r);
      n_r     <= n_r + 1'b1;
    end
  end

  // Magnitudes of the signed sums.
  logic [SUM_W-1:0] absx;
  logic [SUM_W-1:0] absy;
  logic [XY_W-1:0]  absxy;

  assign absx  = sumx_r[SUM_W-1]  ? SUM_W'(-sumx_r)  : SUM_W'(sumx_r);
  assign absy  = sumy_r[SUM_W-1]  ? SUM_W'(-sumy_r)  : SUM_W'(sumy_r);
  assign absxy = sumxy_r[XY_W-1]  ? XY_W'(-sumxy_r)  : XY_W'(sumxy_r);

  // Post-processing registers.
  logic signed [SW-1:0] t_r;
  logic signed [SW-1:0] sxx_r;
  logic signed [SW-1:0] syy_r;
  logic signed [SW-1:0] sxy_r;
  logic [DEN_W-1:0]     num_r;
  logic [DEN_W-1:0]     den_r;
  logic                 neg;
  logic [SW-1:0]        mag;

  assign neg = sxy_r[SW-1];
  assign mag = neg ? SW'(-sxy_r) : SW'(sxy_r);

  // Shared multiplier operand selection.
  logic [OPW-1:0] mul_a;
  logic [OPW-1:0] mul_b;
  logic           mul_neg;
  logic           mul_busy;
  logic           mul_done;
  logic [PW-1:0]  mul_p;

  always_comb begin
    unique case (cmd.mul_sel)
      MS_NSX2: begin
        mul_a = OPW'(sumx2_r); mul_b = OPW'(n_r); mul_neg = 1'b0;
      end
      MS_SXSX: begin
        mul_a = OPW'(absx); mul_b = OPW'(absx); mul_neg = 1'b0;
      end
      MS_NSY2: begin
        mul_a = OPW'(sumy2_r); mul_b = OPW'(n_r); mul_neg = 1'b0;
      end
      MS_SYSY: begin
        mul_a = OPW'(absy); mul_b = OPW'(absy); mul_neg = 1'b0;
      end
      MS_NSXY: begin
        mul_a = OPW'(absxy); mul_b = OPW'(n_r); mul_neg = sumxy_r[XY_W-1];
      end
      MS_SXSY: begin
        mul_a = OPW'(absx); mul_b = OPW'(absy);
        mul_neg = sumx_r[SUM_W-1] ^ sumy_r[SUM_W-1];
      end
      MS_NN1: begin
        mul_a = OPW'(n_r); mul_b = OPW'(n_r - 1'b1); mul_neg = 1'b0;
      end
      MS_MAG2: begin
        mul_a = OPW'(mag); mul_b = OPW'(mag); mul_neg = 1'b0;
      end
      MS_VARP: begin
        mul_a = OPW'(sxx_r); mul_b = OPW'(syy_r); mul_neg = 1'b0;
      end
      default: begin
        mul_a = '0; mul_b = '0; mul_neg = 1'b0;
      end
    endcase
  end

  wpc_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // Signed product, narrowed to the variance width.
  logic signed [SW-1:0] ps;
  assign ps = mul_neg ? -$signed(mul_p[SW-1:0]) : $signed(mul_p[SW-1:0]);

  // Store each product where the sequence needs it.
  always_ff @(posedge clk) begin
    if (mul_done) begin
      unique case (cmd.mul_sel)
        MS_NSX2, MS_NSY2, MS_NSXY: t_r <= ps;
        MS_SXSX: sxx_r <= t_r - ps;
        MS_SYSY: syy_r <= t_r - ps;
        MS_SXSY: sxy_r <= t_r - ps;
        MS_NN1:  den_r <= mul_p[DEN_W-1:0];
        MS_MAG2: num_r <= mul_p[DEN_W-1:0];
        MS_VARP: den_r <= mul_p[DEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider: scaled |Sxy| over n(n-1), or scaled Sxy^2 over Sxx*Syy.
  logic [DVD_W-1:0] dividend;
  logic             div_busy;
  logic             div_done;
  logic [QW-1:0]    quo;

  assign dividend = cov_mode_r ? (DVD_W'(mag) << FRAC_C) : (DVD_W'(num_r) << FRAC_R);

  wpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (den_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // Square root of the quotient gives the correlation magnitude.
  logic              sqrt_busy;
  logic              sqrt_done;
  logic [ROOT_W-1:0] root;

  wpc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (quo[2*ROOT_W-1:0]),
    .busy     (sqrt_busy),
    .done     (sqrt_done),
    .root     (root)
  );

  // Covariance saturates at the edge of the value range.
  logic [QW-1:0]    lim;
  logic [QW-1:0]    cov_mag;
  logic [VAL_W-1:0] res_mag;

  always_comb begin
    lim     = neg ? (QW'(1) << (VAL_W - 1)) : ((QW'(1) << (VAL_W - 1)) - QW'(1));
    cov_mag = (quo > lim) ? lim : quo;
    res_mag = cov_mode_r ? cov_mag[VAL_W-1:0] : VAL_W'(root);
  end

  // Result word.
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        RES_OK: begin
          out_r.value  <= neg ? -$signed(res_mag) : $signed(res_mag);
          out_r.status <= ST_OK;
        end
        RES_FEW: begin
          out_r.value  <= '0;
          out_r.status <= ST_FEW;
        end
        RES_RANGE: begin
          out_r.value  <= '0;
          out_r.status <= ST_RANGE;
        end
        default: begin
          out_r.value  <= '0;
          out_r.status <= ST_FEW;
        end
      endcase
    end
  end

  assign out_data = out_r;

  // Status toward the controller.
  always_comb begin
    st.range_bad = (RNG_W'(sx_r) + RNG_W'(len_r) > RNG_W'(STORE_DEPTH)) ||
                   (RNG_W'(sy_r) + RNG_W'(len_r) > RNG_W'(STORE_DEPTH));
    st.len_zero  = (len_r == '0);
    st.last_read = (k_r == len_r - 1'b1);
    st.few_pairs = (n_r <= LEN_W'(MIN_PAIRS));
    st.var_zero  = (sxx_r == '0) || (syy_r == '0);
    st.cov_mode  = cov_mode_r;
    st.mul_done  = mul_done;
    st.div_done  = div_done;
    st.sqrt_done = sqrt_done;
    st.mul_busy  = mul_busy;
    st.div_busy  = div_busy;
    st.sqrt_busy = sqrt_busy;
  end

endmodule

`default_nettype wire

// ----- rtl/core/wpc_ctrl.sv -----
// Controller: sequences window reads, the product chain, division and root,
// and owns the handshake on both channels. Depends on wpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wpc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  input  logic              out_ready,
  input  wpc_pkg::dp_stat_t st,
  output logic              in_ready,
  output logic              out_valid,
  output wpc_pkg::dp_cmd_t  cmd
);
  import wpc_pkg::*;

  localparam int DR_W = $clog2(DRAIN_CYC + 1);

  ctrl_state_t state_r, state_nxt;
  mul_sel_t    mstep_r, mstep_nxt;
  res_kind_t   res_r, res_nxt;
  logic [DR_W-1:0] drain_r, drain_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        res_load;

  assign res_load = (state_r == S_RESULT) && (!out_valid_r || out_ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    mstep_nxt = mstep_r;
    res_nxt   = res_r;
    drain_nxt = drain_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && (in_kind == KIND_COMPUTE)) state_nxt = S_RANGE;
      end
      S_RANGE: begin
        drain_nxt = '0;
        if (st.range_bad) begin
          res_nxt   = RES_RANGE;
          state_nxt = S_RESULT;
        end else if (st.len_zero) begin
          state_nxt = S_DRAIN;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        if (st.last_read) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == DR_W'(DRAIN_CYC - 1)) state_nxt = S_COUNT;
      end
      S_COUNT: begin
        if (st.few_pairs) begin
          res_nxt   = RES_FEW;
          state_nxt = S_RESULT;
        end else begin
          mstep_nxt = MS_NSX2;
          state_nxt = S_MUL_GO;
        end
      end
      S_MUL_GO: state_nxt = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (st.mul_done) begin
          state_nxt = S_MUL_GO;
          unique case (mstep_r)
            MS_NSX2: mstep_nxt = MS_SXSX;
            MS_SXSX: mstep_nxt = MS_NSY2;
            MS_NSY2: mstep_nxt = MS_SYSY;
            MS_SYSY: mstep_nxt = MS_NSXY;
            MS_NSXY: mstep_nxt = MS_SXSY;
            MS_SXSY: state_nxt = S_VAR;
            MS_MAG2: mstep_nxt = MS_VARP;
            MS_NN1, MS_VARP: state_nxt = S_DIV_GO;
            default: state_nxt = S_DIV_GO;
          endcase
        end
      end
      S_VAR: begin
        if (st.var_zero) begin
          res_nxt   = RES_FEW;
          state_nxt = S_RESULT;
        end else begin
          mstep_nxt = st.cov_mode ? MS_NN1 : MS_MAG2;
          state_nxt = S_MUL_GO;
        end
      end
      S_DIV_GO: state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (st.div_done) begin
          if (st.cov_mode) begin
            res_nxt   = RES_OK;
            state_nxt = S_RESULT;
          end else begin
            state_nxt = S_SQRT_GO;
          end
        end
      end
      S_SQRT_GO: state_nxt = S_SQRT_WAIT;
      S_SQRT_WAIT: begin
        if (st.sqrt_done) begin
          res_nxt   = RES_OK;
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs toward the datapath and the channels.
  always_comb begin
    in_ready       = (state_r == S_IDLE);
    cmd.in_take    = in_valid && (state_r == S_IDLE);
    cmd.rd_en      = (state_r == S_READ);
    cmd.mul_start  = (state_r == S_MUL_GO);
    cmd.mul_sel    = mstep_r;
    cmd.div_start  = (state_r == S_DIV_GO);
    cmd.sqrt_start = (state_r == S_SQRT_GO);
    cmd.res_load   = res_load;
    cmd.res_kind   = res_r;
    out_valid_nxt  = res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mstep_r     <= MS_NSX2;
      res_r       <= RES_OK;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mstep_r     <= mstep_nxt;
      res_r       <= res_nxt;
      drain_r     <= drain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- rtl/core/windowed_pearson_correlation.sv -----
// Top level of the windowed correlation engine: controller plus datapath.
// Depends on wpc_pkg, wpc_ctrl, wpc_datapath and assert_macros.svh.
//
//   Channel  Signals                          Word
//   in       in_valid, in_ready, in_data      load pair or compute window
//   out      out_valid, out_ready, out_data   value and status
//   cfg      cfg_we, cfg_index, cfg_wdata     covariance_mode, missing_code
//
// A load word with an index inside the stores is written as it is taken. A compute
// word runs through the store reads and the read pipeline, then a bit-serial
// multiply chain, long division and, for correlation, a square root. The store
// read port and the serial units set its duration. rst_n is synchronous; the
// stores are not cleared. A finished result waits in the output register while
// the next word is accepted; a second result waits for that register to free up.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module windowed_pearson_correlation #(
  parameter int STORE_DEPTH = wpc_pkg::STORE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wpc_pkg::in_word_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wpc_pkg::out_word_t             out_data,
  input  logic                           cfg_we,
  input  logic [wpc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wpc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  wpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_data.kind),
    .out_ready (out_ready),
    .st        (st),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  wpc_datapath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

  // No iterative unit may still be running while a new word can be taken.
  `WPC_ASSERT_NOW(a_idle_units, in_ready, !(st.mul_busy || st.div_busy || st.sqrt_busy), "unit busy while idle")
  // A new result never overwrites a word still waiting on the output.
  `WPC_ASSERT_NOW(a_no_overwrite, cmd.res_load, !out_valid || out_ready, "result overwrote pending word")
  // A result loaded with a flagged status carries a zero value.
  `WPC_ASSERT_NEXT(a_flag_zero, cmd.res_load && (cmd.res_kind != RES_OK), out_data.value == '0, "flagged result not zero")

endmodule

`default_nettype wire
